// ===== hw/rtl/ilir_pkg.sv =====
// Shared types and constants for the indexed list insert/remove block.
// Used by every module in hw/rtl; depends on nothing else.
package ilir_pkg;

  // Storage geometry.
  localparam int DEPTH   = 256;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);

  // Fixed field widths of the request and response words.
  localparam int REQ_W   = 3;
  localparam int IDX_W   = 9;
  localparam int STAT_W  = 3;

  // Depth of the command queue between the front and the back.
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Request codes as they arrive on the input channel.
  localparam logic [REQ_W-1:0] REQ_READ   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_INSERT = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_RESIZE = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_MODE_FIXED   = 1'b0;
  localparam logic CFG_MODE_MUTABLE = 1'b1;

  // Response status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_IMMUTABLE = 3'd1,
    ST_FIXED     = 3'd2,
    ST_RANGE     = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  // Command kinds after classification by the front.
  typedef enum logic [2:0] {
    K_READ,
    K_WRITE,
    K_INSERT,
    K_REMOVE,
    K_RESIZE,
    K_NOP,
    K_FAIL
  } kind_t;

  // One classified command as it travels through the queue.
  typedef struct packed {
    kind_t              kind;
    status_t            status;
    logic [IDX_W-1:0]   index;
    logic [DATA_W-1:0]  value;
    logic [CNT_W-1:0]   new_size;
  } cmd_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SHIFT_UP,
    BK_INS_LAST,
    BK_INS_WORD,
    BK_RM_SHIFT,
    BK_RM_LAST,
    BK_FILL,
    BK_RESP
  } bk_state_t;

endpackage

// ===== hw/rtl/ilir_front.sv =====
// Front end: accepts request words and classifies them into queue commands.
// Mode checks happen here; range and capacity checks are left to the back.
// Depends on ilir_pkg.
module ilir_front
  import ilir_pkg::*;
(
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [REQ_W-1:0]  in_req_type,
  input  logic [IDX_W-1:0]  in_index,
  input  logic [DATA_W-1:0] in_value,
  input  logic [IDX_W-1:0]  in_new_size,
  input  logic              mode_fixed,
  input  logic              mode_mutable,
  input  logic              q_full,
  output logic              q_push,
  output cmd_t              q_cmd
);

  kind_t kind;
  logic  is_mod;
  logic  is_shape;

  // Decode the request code.
  always_comb begin
    case (in_req_type)
      REQ_READ:   kind = K_READ;
      REQ_WRITE:  kind = K_WRITE;
      REQ_INSERT: kind = K_INSERT;
      REQ_REMOVE: kind = K_REMOVE;
      REQ_RESIZE: kind = K_RESIZE;
      default:    kind = K_NOP;
    endcase
  end

  // Modifying requests need a mutable list; shape changes also need a resizable one.
  assign is_mod   = (kind == K_WRITE) || (kind == K_INSERT) || (kind == K_REMOVE)
                    || (kind == K_RESIZE);
  assign is_shape = (kind == K_INSERT) || (kind == K_REMOVE) || (kind == K_RESIZE);

  always_comb begin
    q_cmd.kind     = kind;
    q_cmd.status   = ST_OK;
    q_cmd.index    = in_index;
    q_cmd.value    = in_value;
    q_cmd.new_size = CNT_W'(in_new_size);
    if (is_mod && !mode_mutable) begin
      q_cmd.kind   = K_FAIL;
      q_cmd.status = ST_IMMUTABLE;
    end else if (is_shape && mode_fixed) begin
      q_cmd.kind   = K_FAIL;
      q_cmd.status = ST_FIXED;
    end
  end

  // The queue absorbs words until it fills.
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

endmodule

// ===== hw/rtl/ilir_cmdq.sv =====
// Short command queue between the front and the back.
// Holds classified commands so that each side can stall on its own. Depends on ilir_pkg.
module ilir_cmdq
  import ilir_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t head_cmd
);

  cmd_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign valid    = (cnt_r != '0);
  assign head_cmd = slot_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  // Pointer and fill-level updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage carries payload only.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== hw/rtl/ilir_back.sv =====
// Back end: executes queued commands against the entry memory and the count.
// Shifts walk the memory one entry per cycle; results leave through an output register.
// Depends on ilir_pkg.
module ilir_back
  import ilir_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  cmd_t              q_cmd,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] out_data,
  output logic [STAT_W-1:0] out_status,
  output logic [CNT_W-1:0]  out_count
);

  // Entry memory: one write port, one registered read port.
  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;
  logic              we;
  logic [ADDR_W-1:0] wa;
  logic [DATA_W-1:0] wd;
  logic [ADDR_W-1:0] ra;

  bk_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  ptr_r, ptr_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [CNT_W-1:0]  nsize_r, nsize_nxt;
  logic              sh_v_r, sh_v_nxt;
  logic [ADDR_W-1:0] sh_wa_r, sh_wa_nxt;
  logic              cap_r, cap_nxt;
  logic [DATA_W-1:0] res_data_r, res_data_nxt;
  status_t           res_status_r, res_status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [CNT_W-1:0]  out_count_r, out_count_nxt;
  logic              out_free;
  logic [CNT_W-1:0]  last_idx;

  assign out_free = !out_valid_r || !out_stall;
  assign last_idx = count_r - 1'b1;

  // Sequencer: next state, memory controls and result formation.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    idx_nxt        = idx_r;
    val_nxt        = val_r;
    nsize_nxt      = nsize_r;
    sh_v_nxt       = 1'b0;
    sh_wa_nxt      = sh_wa_r;
    cap_nxt        = 1'b0;
    res_data_nxt   = cap_r ? rdata_r : res_data_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    q_pop          = 1'b0;
    // A word read during a shift is written at its new place in the next cycle.
    we             = sh_v_r;
    wa             = sh_wa_r;
    wd             = rdata_r;
    ra             = ptr_r[ADDR_W-1:0];

    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop          = 1'b1;
          idx_nxt        = q_cmd.index;
          val_nxt        = q_cmd.value;
          nsize_nxt      = q_cmd.new_size;
          res_data_nxt   = '0;
          res_status_nxt = q_cmd.status;
          state_nxt      = BK_RESP;
          case (q_cmd.kind)
            K_READ: begin
              if (q_cmd.index >= count_r) begin
                res_status_nxt = ST_RANGE;
              end else begin
                ra      = q_cmd.index[ADDR_W-1:0];
                cap_nxt = 1'b1;
              end
            end
            K_WRITE: begin
              if (q_cmd.index >= count_r) begin
                res_status_nxt = ST_RANGE;
              end else begin
                we = 1'b1;
                wa = q_cmd.index[ADDR_W-1:0];
                wd = q_cmd.value;
              end
            end
            K_INSERT: begin
              if (q_cmd.index > count_r) begin
                res_status_nxt = ST_RANGE;
              end else if (count_r == CNT_W'(DEPTH)) begin
                res_status_nxt = ST_FULL;
              end else if (q_cmd.index == count_r) begin
                state_nxt = BK_INS_WORD;
              end else begin
                ptr_nxt   = last_idx;
                state_nxt = BK_SHIFT_UP;
              end
            end
            K_REMOVE: begin
              if (q_cmd.index >= count_r) begin
                res_status_nxt = ST_RANGE;
              end else begin
                ptr_nxt   = CNT_W'(q_cmd.index);
                state_nxt = BK_RM_SHIFT;
              end
            end
            K_RESIZE: begin
              if (q_cmd.new_size > CNT_W'(DEPTH)) begin
                res_status_nxt = ST_FULL;
              end else begin
                count_nxt = q_cmd.new_size;
                if (count_r < q_cmd.new_size) begin
                  ptr_nxt   = count_r;
                  state_nxt = BK_FILL;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Walk down from the top entry, moving each word up by one.
      BK_SHIFT_UP: begin
        ra        = ptr_r[ADDR_W-1:0];
        sh_v_nxt  = 1'b1;
        sh_wa_nxt = ADDR_W'(ptr_r + 1'b1);
        if (ptr_r == CNT_W'(idx_r)) begin
          state_nxt = BK_INS_LAST;
        end else begin
          ptr_nxt = ptr_r - 1'b1;
        end
      end

      // The last moved word is written here by the shift write-back.
      BK_INS_LAST: begin
        state_nxt = BK_INS_WORD;
      end

      BK_INS_WORD: begin
        we        = 1'b1;
        wa        = idx_r[ADDR_W-1:0];
        wd        = val_r;
        count_nxt = count_r + 1'b1;
        state_nxt = BK_RESP;
      end

      // Walk up from the removed entry; the first read is the removed word.
      BK_RM_SHIFT: begin
        ra        = ptr_r[ADDR_W-1:0];
        cap_nxt   = (ptr_r == CNT_W'(idx_r));
        sh_v_nxt  = (ptr_r != CNT_W'(idx_r));
        sh_wa_nxt = ADDR_W'(ptr_r - 1'b1);
        if (ptr_r == last_idx) begin
          state_nxt = BK_RM_LAST;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end

      BK_RM_LAST: begin
        count_nxt = count_r - 1'b1;
        state_nxt = BK_RESP;
      end

      // Newly exposed entries read as zero.
      BK_FILL: begin
        we      = 1'b1;
        wa      = ptr_r[ADDR_W-1:0];
        wd      = '0;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r + 1'b1 == nsize_r) begin
          state_nxt = BK_RESP;
        end
      end

      BK_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = cap_r ? rdata_r : res_data_r;
          out_status_nxt = res_status_r;
          out_count_nxt  = count_r;
          state_nxt      = BK_IDLE;
        end
      end

      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      count_r     <= '0;
      sh_v_r      <= 1'b0;
      cap_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sh_v_r      <= sh_v_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    idx_r        <= idx_nxt;
    val_r        <= val_nxt;
    nsize_r      <= nsize_nxt;
    sh_wa_r      <= sh_wa_nxt;
    res_data_r   <= res_data_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  // Entry memory.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_r <= mem[ra];
  end

  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;

endmodule

// ===== hw/rtl/indexed_list_insert_remove_top.sv =====
// Indexed list of data words with a live element count.
//
// Input channel (in_valid / in_stall): one request word per transfer carrying
// in_req_type (0 read, 1 write, 2 insert, 3 remove, 4 resize), in_index,
// in_value and in_new_size. Each request yields exactly one response word on
// the output channel (out_valid / out_stall) with out_data, out_status and
// out_count. Codes 5 to 7 answer ok without any effect.
// Configuration (cfg_valid / cfg_ready): index 0 is mode_fixed, index 1 is
// mode_mutable; both reset to 1. cfg_ready is always high.
// Insert and remove shift the tail of the list, and a growing resize zero-fills
// the new entries, one word per cycle through the entry memory's single write
// port; read, write, failed requests and a resize that does not grow need no
// walk. The back works on one request at a time. A two-entry command queue
// lets the front keep accepting while the back works.
// Reset empties the list (count 0) and the queue; entry contents are not cleared.
// A stalled response holds in the output register; the back waits behind it and
// the input stalls once the command queue is full.
module indexed_list_insert_remove_top
  import ilir_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [REQ_W-1:0]  in_req_type,
  input  logic [IDX_W-1:0]  in_index,
  input  logic [DATA_W-1:0] in_value,
  input  logic [IDX_W-1:0]  in_new_size,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] out_data,
  output logic [STAT_W-1:0] out_status,
  output logic [CNT_W-1:0]  out_count,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic              cfg_data
);

  logic mode_fixed_r, mode_fixed_nxt;
  logic mode_mutable_r, mode_mutable_nxt;
  logic q_full;
  logic q_push;
  cmd_t q_in;
  logic q_pop;
  logic q_valid;
  cmd_t q_head;

  // Mode registers.
  assign cfg_ready = 1'b1;

  always_comb begin
    mode_fixed_nxt   = mode_fixed_r;
    mode_mutable_nxt = mode_mutable_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODE_FIXED:   mode_fixed_nxt   = cfg_data;
        CFG_MODE_MUTABLE: mode_mutable_nxt = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_fixed_r   <= 1'b1;
      mode_mutable_r <= 1'b1;
    end else begin
      mode_fixed_r   <= mode_fixed_nxt;
      mode_mutable_r <= mode_mutable_nxt;
    end
  end

  ilir_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_index     (in_index),
    .in_value     (in_value),
    .in_new_size  (in_new_size),
    .mode_fixed   (mode_fixed_r),
    .mode_mutable (mode_mutable_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_in)
  );

  ilir_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head_cmd (q_head)
  );

  ilir_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .out_status (out_status),
    .out_count  (out_count)
  );

  // A failed request never returns a data word.
  a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_data == '0))
    else $error("failed response carries data");

  // An immutable error only appears while the list is immutable.
  a_immutable_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_IMMUTABLE) |-> !mode_mutable_r)
    else $error("immutable status while mutable");

  // A fixed-size error only appears while the list is fixed and mutable.
  a_fixed_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FIXED) |-> (mode_fixed_r && mode_mutable_r))
    else $error("fixed status with wrong modes");

  // The reported count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_count <= CNT_W'(DEPTH)))
    else $error("count above capacity");

endmodule
